// ----- design/brf_pkg.sv -----
// brf_pkg: shared types and constants for the byte ring fifo
// holds field widths, operation codes and controller/datapath interface structs
// no dependencies
package brf_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 16;
    localparam int FILL_W = 9;
    localparam int OVF_W  = 16;
    localparam int CFG_W  = 9;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_PEEK   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic accept;      // input transaction taken this cycle
        logic cfg_write;   // capacity register written this cycle
        logic in_burst;    // streaming burst bytes
        logic load_byte;   // move one burst byte into the output register
    } brf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic burst_go;    // offered item is a burst that returns bytes
        logic last_byte;   // current burst byte is the final one
    } brf_status_t;

endpackage

// ----- design/brf_ram.sv -----
// brf_ram: generic single write port, single read port ram with registered read
// no dependencies
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/brf_ctrl.sv -----
// brf_ctrl: controller state machine for the byte ring fifo
// sequences single-result items and burst byte streaming; depends on brf_pkg
module brf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  brf_pkg::brf_status_t status,
    output brf_pkg::brf_cmd_t    cmd
);

    import brf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } state_t;

    state_t state_reg;
    logic   idle;

    assign idle      = (state_reg == ST_IDLE);
    assign cfg_ready = idle;
    // config has priority over a new item
    assign s_ready   = idle && status.out_free && !cfg_valid;

    always_comb begin
        cmd.accept    = s_valid && s_ready;
        cmd.cfg_write = cfg_valid && cfg_ready;
        cmd.in_burst  = !idle;
        cmd.load_byte = !idle && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.accept && status.burst_go) begin
                        state_reg <= ST_BURST;
                    end
                end
                ST_BURST: begin
                    if (status.out_free && status.last_byte) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/brf_dp.sv -----
// brf_dp: datapath of the byte ring fifo
// ring pointers, occupancy, overflow counter, byte store and output register
// depends on brf_pkg and brf_ram
module brf_dp #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  brf_pkg::brf_cmd_t            cmd,
    output brf_pkg::brf_status_t         status,
    input  logic [brf_pkg::CFG_W-1:0]    cfg_data,
    input  logic [brf_pkg::OP_W-1:0]     s_operation,
    input  logic [brf_pkg::BYTE_W-1:0]   s_wr_byte,
    input  logic [brf_pkg::CNT_W-1:0]    s_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [brf_pkg::BYTE_W-1:0]   m_rd_byte,
    output logic                         m_ok,
    output logic                         m_last,
    output logic [brf_pkg::FILL_W-1:0]   m_fill_level,
    output logic [brf_pkg::OVF_W-1:0]    m_overflow_total
);

    import brf_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int RW   = $clog2(MAX_BURST + 1);
    localparam int SUMW = ((AW > FILL_W) ? AW : FILL_W) + 1;
    localparam logic [CFG_W-1:0] DEPTH_CAP =
        (DEPTH > 511) ? 9'd511 : DEPTH[CFG_W-1:0];
    localparam logic [CFG_W-1:0] RESET_CAP =
        (DEPTH_CAP < 9'd256) ? DEPTH_CAP : 9'd256;
    localparam logic [CNT_W-1:0] MAX_BURST_C = MAX_BURST[CNT_W-1:0];
    localparam logic [OVF_W-1:0] OVF_MAX = {OVF_W{1'b1}};

    // state
    logic [CFG_W-1:0]  cap_reg,     cap_next;
    logic [AW-1:0]     head_reg,    head_next;
    logic [AW-1:0]     tail_reg,    tail_next;
    logic [FILL_W-1:0] held_reg,    held_next;
    logic [OVF_W-1:0]  dropped_reg, dropped_next;
    logic [AW-1:0]     pos_reg,     pos_next;
    logic [RW-1:0]     rem_reg,     rem_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg,  out_byte_next;
    logic              out_ok_reg,    out_ok_next;
    logic              out_last_reg,  out_last_next;
    logic [FILL_W-1:0] out_fill_reg,  out_fill_next;
    logic [OVF_W-1:0]  out_ovf_reg,   out_ovf_next;

    // ram
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    op_t               op;
    logic              full;
    logic              burst_req;
    logic              burst_bad;
    logic              load_single;
    logic              single_ok;
    logic [AW-1:0]     pos_inc;

    // (pos + by) mod cap, with pos < cap and by <= cap
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos,
                                               input logic [FILL_W-1:0] by,
                                               input logic [CFG_W-1:0] cap);
        logic [SUMW-1:0] sum;
        logic [SUMW-1:0] capw;
        sum  = SUMW'(pos) + SUMW'(by);
        capw = SUMW'(cap);
        if (sum >= capw) begin
            sum = sum - capw;
        end
        return sum[AW-1:0];
    endfunction

    assign op        = op_t'(s_operation);
    assign full      = (held_reg >= cap_reg);
    assign burst_req = (op == OP_READ) || (op == OP_PEEK);
    assign burst_bad = (s_count > MAX_BURST_C) || (s_count > CNT_W'(held_reg));
    assign pos_inc   = wrap_add(pos_reg, FILL_W'(1), cap_reg);

    always_comb begin
        status.out_free  = !out_valid_reg || m_ready;
        status.burst_go  = burst_req && !burst_bad && (s_count != '0);
        status.last_byte = (rem_reg == RW'(1));
    end

    assign load_single = cmd.accept && !status.burst_go;

    always_comb begin
        cap_next     = cap_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        held_next    = held_reg;
        dropped_next = dropped_reg;
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        ram_we       = 1'b0;
        single_ok    = 1'b1;

        if (cmd.cfg_write) begin
            if (cfg_data < 9'd2) begin
                cap_next = 9'd2;
            end else if (cfg_data > DEPTH_CAP) begin
                cap_next = DEPTH_CAP;
            end else begin
                cap_next = cfg_data;
            end
            head_next    = '0;
            tail_next    = '0;
            held_next    = '0;
            dropped_next = '0;
        end else if (cmd.accept) begin
            case (op)
                OP_WRITE: begin
                    if (full) begin
                        single_ok = 1'b0;
                        if (dropped_reg != OVF_MAX) begin
                            dropped_next = dropped_reg + OVF_W'(1);
                        end
                    end else begin
                        ram_we    = 1'b1;
                        tail_next = wrap_add(tail_reg, FILL_W'(1), cap_reg);
                        held_next = held_reg + FILL_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (s_count <= CNT_W'(held_reg)) begin
                        head_next = wrap_add(head_reg, s_count[FILL_W-1:0], cap_reg);
                        held_next = held_reg - s_count[FILL_W-1:0];
                    end else begin
                        head_next = tail_reg;
                        held_next = '0;
                    end
                end
                default: begin
                    if (burst_bad) begin
                        single_ok = 1'b0;
                    end else if (status.burst_go) begin
                        pos_next = head_reg;
                        rem_next = s_count[RW-1:0];
                        if (op == OP_READ) begin
                            head_next = wrap_add(head_reg, s_count[FILL_W-1:0], cap_reg);
                            held_next = held_reg - s_count[FILL_W-1:0];
                        end
                    end
                end
            endcase
        end else if (cmd.load_byte) begin
            pos_next = pos_inc;
            rem_next = rem_reg - RW'(1);
        end
    end

    // hold the read address while the output stalls so the ram data stays put
    always_comb begin
        if (!cmd.in_burst) begin
            ram_raddr = head_reg;
        end else if (cmd.load_byte) begin
            ram_raddr = pos_inc;
        end else begin
            ram_raddr = pos_reg;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        out_fill_next  = out_fill_reg;
        out_ovf_next   = out_ovf_reg;
        if (load_single) begin
            out_valid_next = 1'b1;
            out_byte_next  = '0;
            out_ok_next    = single_ok;
            out_last_next  = 1'b1;
            out_fill_next  = held_next;
            out_ovf_next   = dropped_next;
        end else if (cmd.load_byte) begin
            out_valid_next = 1'b1;
            out_byte_next  = ram_rdata;
            out_ok_next    = 1'b1;
            out_last_next  = status.last_byte;
            out_fill_next  = held_reg;
            out_ovf_next   = dropped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= RESET_CAP;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            dropped_reg   <= '0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            held_reg      <= held_next;
            dropped_reg   <= dropped_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
        out_fill_reg <= out_fill_next;
        out_ovf_reg  <= out_ovf_next;
    end

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (s_wr_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid          = out_valid_reg;
    assign m_rd_byte        = out_byte_reg;
    assign m_ok             = out_ok_reg;
    assign m_last           = out_last_reg;
    assign m_fill_level     = out_fill_reg;
    assign m_overflow_total = out_ovf_reg;

endmodule

// ----- design/byte_ring_fifo.sv -----
// byte_ring_fifo: byte fifo in a ring store with configurable capacity
// write, remove and failed or empty bursts: one result per transaction
// bursts of n bytes: accepted, then one byte per cycle from the store's read port while m_ready allows
// results reach the output register in the cycle after acceptance or ram read; output register stalls on m_ready
// reset: empty buffer, overflow count zero, capacity 256 clamped to DEPTH, store left unset
// depends on brf_pkg, brf_ctrl, brf_dp, brf_ram
module byte_ring_fifo #(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // capacity register write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [brf_pkg::CFG_W-1:0]    cfg_data,

    // operation channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [brf_pkg::OP_W-1:0]     s_operation,
    input  logic [brf_pkg::BYTE_W-1:0]   s_wr_byte,
    input  logic [brf_pkg::CNT_W-1:0]    s_count,

    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [brf_pkg::BYTE_W-1:0]   m_rd_byte,
    output logic                         m_ok,
    output logic                         m_last,
    output logic [brf_pkg::FILL_W-1:0]   m_fill_level,
    output logic [brf_pkg::OVF_W-1:0]    m_overflow_total
);

    import brf_pkg::*;

    // command and status between the controller and the datapath
    brf_cmd_t    cmd;
    brf_status_t status;

    // controller: idle takes single transactions, burst streams bytes
    brf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: pointers, counters, byte store and the output register
    brf_dp #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_data         (cfg_data),
        .s_operation      (s_operation),
        .s_wr_byte        (s_wr_byte),
        .s_count          (s_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rd_byte        (m_rd_byte),
        .m_ok             (m_ok),
        .m_last           (m_last),
        .m_fill_level     (m_fill_level),
        .m_overflow_total (m_overflow_total)
    );

endmodule

// ----- tb/tb_byte_ring_fifo.sv -----
// tb_byte_ring_fifo: self-checking testbench for the byte ring fifo
// drives operation transactions, predicts every result in a local fifo model, checks all fields
// depends on brf_pkg and byte_ring_fifo
`timescale 1ns / 1ps

module tb_byte_ring_fifo;
    import brf_pkg::*;

    localparam int DEPTH       = 256;
    localparam int MAX_BURST   = 16;
    localparam int CYCLE_LIMIT = 600000;

    // one operation transaction as driven on the s_ channel
    typedef struct {
        op_t                op;
        logic [BYTE_W-1:0]  data;
        logic [CNT_W-1:0]   count;
    } fifo_op_t;

    // one result transaction as seen on the m_ channel
    typedef struct {
        logic [BYTE_W-1:0]  rd_byte;
        logic               ok;
        logic               last;
        logic [FILL_W-1:0]  fill;
        logic [OVF_W-1:0]   ovf;
    } fifo_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_operation = '0;
    logic [BYTE_W-1:0]    s_wr_byte   = '0;
    logic [CNT_W-1:0]     s_count     = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [BYTE_W-1:0]    m_rd_byte;
    logic                 m_ok;
    logic                 m_last;
    logic [FILL_W-1:0]    m_fill_level;
    logic [OVF_W-1:0]     m_overflow_total;

    // stimulus and scoreboard
    fifo_op_t      op_queue[$];
    fifo_result_t  owed_results[$];
    fifo_result_t  got_want;
    fifo_op_t      next_op;
    int            error_count = 0;
    int            cycle_count = 0;
    bit            idling_on   = 1'b1;
    int            send_gap    = 0;
    int            recv_gap    = 0;

    // fifo model state
    logic [BYTE_W-1:0]  fifo_store [DEPTH];
    int                 head_idx    = 0;
    int                 tail_idx    = 0;
    int                 held_bytes  = 0;
    logic [OVF_W-1:0]   drop_total  = '0;
    logic [CFG_W-1:0]   cap_setting = 9'd256;

    // occupancy as seen by the stimulus generator, used to shape bursts
    int gen_level = 0;
    int gen_slots = DEPTH;

    // capacity settings for the random phases, last one picked at run time
    int cap_plan [8] = '{3, 17, 511, 0, 100, 1, 257, 0};

    byte_ring_fifo #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_wr_byte        (s_wr_byte),
        .s_count          (s_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rd_byte        (m_rd_byte),
        .m_ok             (m_ok),
        .m_last           (m_last),
        .m_fill_level     (m_fill_level),
        .m_overflow_total (m_overflow_total)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // register value to slots in use: below 2 acts as 2, above DEPTH as DEPTH
    function automatic int slots_in_use(logic [CFG_W-1:0] setting);
        if (setting < 2) return 2;
        if (setting > DEPTH) return DEPTH;
        return int'(setting);
    endfunction

    // result carries the occupancy and drop count after the operation
    task automatic owe_result(logic [BYTE_W-1:0] rd, logic ok, logic last);
        fifo_result_t r;
        r.rd_byte = rd;
        r.ok      = ok;
        r.last    = last;
        r.fill    = FILL_W'(held_bytes);
        r.ovf     = drop_total;
        owed_results.push_back(r);
    endtask

    // advance the fifo model by one accepted operation and queue its results
    task automatic apply_fifo_op(op_t op, logic [BYTE_W-1:0] wb, logic [CNT_W-1:0] cnt);
        int cap;
        int pos;
        int n;
        cap = slots_in_use(cap_setting);
        n   = int'(cnt);
        case (op)
            OP_WRITE: begin
                if (held_bytes >= cap) begin
                    // full: nothing stored, drop count saturates
                    if (drop_total != '1) drop_total++;
                    owe_result('0, 1'b0, 1'b1);
                end else begin
                    fifo_store[tail_idx] = wb;
                    tail_idx = (tail_idx + 1) % cap;
                    held_bytes++;
                    owe_result('0, 1'b1, 1'b1);
                end
            end
            OP_REMOVE: begin
                if (n <= held_bytes) begin
                    head_idx   = (head_idx + n) % cap;
                    held_bytes = held_bytes - n;
                end else begin
                    // more than held: buffer empties
                    head_idx   = tail_idx;
                    held_bytes = 0;
                end
                owe_result('0, 1'b1, 1'b1);
            end
            default: begin
                if (n > MAX_BURST || n > held_bytes) begin
                    owe_result('0, 1'b0, 1'b1);
                end else if (n == 0) begin
                    owe_result('0, 1'b1, 1'b1);
                end else begin
                    pos = head_idx;
                    // a read consumes before any byte goes out, a peek leaves state alone
                    if (op == OP_READ) begin
                        head_idx   = (head_idx + n) % cap;
                        held_bytes = held_bytes - n;
                    end
                    for (int i = 0; i < n; i++) begin
                        owe_result(fifo_store[pos], 1'b1, i == n - 1);
                        pos = (pos + 1) % cap;
                    end
                end
            end
        endcase
    endtask

    task automatic queue_op(op_t op, logic [BYTE_W-1:0] data, logic [CNT_W-1:0] count);
        fifo_op_t t;
        t.op    = op;
        t.data  = data;
        t.count = count;
        op_queue.push_back(t);
    endtask

    // idle point: every operation taken and every result back
    task automatic wait_drained();
        do @(negedge aclk);
        while (op_queue.size() != 0 || s_valid || owed_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // capacity write; the fifo model empties along with the block
    task automatic write_capacity(logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cap_setting = value;
        head_idx    = 0;
        tail_idx    = 0;
        held_bytes  = 0;
        drop_total  = '0;
        gen_level   = 0;
        gen_slots   = slots_in_use(value);
    endtask

    // writes, bursts and removes; bursts mostly fit what is held, with some oversize and random counts
    task automatic random_phase(int n);
        int r;
        int cnt;
        int fit;
        op_t op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                queue_op(OP_WRITE, BYTE_W'($urandom), CNT_W'($urandom));
                if (gen_level < gen_slots) gen_level++;
            end else if (r < 82) begin
                op  = (r < 64) ? OP_READ : OP_PEEK;
                fit = (gen_level < MAX_BURST) ? gen_level : MAX_BURST;
                case ($urandom_range(0, 9))
                    0:       cnt = $urandom_range(0, 65535);
                    1:       cnt = MAX_BURST + $urandom_range(1, 3);
                    2:       cnt = gen_level + 1;
                    default: cnt = $urandom_range(0, fit);
                endcase
                queue_op(op, BYTE_W'($urandom), CNT_W'(cnt));
                if (op == OP_READ && cnt <= fit) gen_level -= cnt;
            end else begin
                cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 3);
                queue_op(OP_REMOVE, BYTE_W'($urandom), CNT_W'(cnt));
                gen_level = (cnt > gen_level) ? 0 : gen_level - cnt;
            end
        end
    endtask

    // driver: presents queued operations, idles in bursts between transactions
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            // transaction taken at this edge: predict its results
            if (s_valid && s_ready)
                apply_fifo_op(op_t'(s_operation), s_wr_byte, s_count);
            // valid only drops or changes once the held transaction is taken
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    s_valid  <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    next_op     = op_queue.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= next_op.op;
                    s_wr_byte   <= next_op.data;
                    s_count     <= next_op.count;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    flag_error($sformatf("unexpected result: byte %02h ok %0b last %0b",
                                         m_rd_byte, m_ok, m_last));
                end else begin
                    got_want = owed_results.pop_front();
                    if (m_rd_byte !== got_want.rd_byte)
                        flag_error($sformatf("rd_byte got %02h want %02h",
                                             m_rd_byte, got_want.rd_byte));
                    if (m_ok !== got_want.ok)
                        flag_error($sformatf("ok got %0b want %0b", m_ok, got_want.ok));
                    if (m_last !== got_want.last)
                        flag_error($sformatf("last got %0b want %0b", m_last, got_want.last));
                    if (m_fill_level !== got_want.fill)
                        flag_error($sformatf("fill_level got %0d want %0d",
                                             m_fill_level, got_want.fill));
                    if (m_overflow_total !== got_want.ovf)
                        flag_error($sformatf("overflow_total got %0d want %0d",
                                             m_overflow_total, got_want.ovf));
                end
            end
            // receiver stalls at random, in bursts
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 6);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // hang guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // directed, reset capacity: empty-buffer cases, byte extremes, burst rejects
        queue_op(OP_PEEK,   8'h00, 16'd0);
        queue_op(OP_READ,   8'hFF, 16'd1);
        queue_op(OP_REMOVE, 8'h00, 16'd0);
        queue_op(OP_REMOVE, 8'h00, 16'hFFFF);
        queue_op(OP_WRITE,  8'h00, 16'hFFFF);
        queue_op(OP_WRITE,  8'hFF, 16'd0);
        queue_op(OP_WRITE,  8'hA5, 16'd0);
        queue_op(OP_WRITE,  8'h5A, 16'd0);
        queue_op(OP_PEEK,   8'h00, 16'd4);
        queue_op(OP_READ,   8'h00, 16'd17);
        queue_op(OP_READ,   8'h00, 16'd2);
        queue_op(OP_PEEK,   8'h00, 16'hFFFF);
        queue_op(OP_REMOVE, 8'h00, 16'd1);
        queue_op(OP_READ,   8'h00, 16'd1);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        // smallest capacity: overflow, bursts and a remove ending exactly at the wrap
        write_capacity(9'd2);
        queue_op(OP_WRITE,  8'h11, 16'd0);
        queue_op(OP_WRITE,  8'h22, 16'd0);
        queue_op(OP_WRITE,  8'h33, 16'd0);
        queue_op(OP_READ,   8'h00, 16'd2);
        queue_op(OP_WRITE,  8'h44, 16'd0);
        queue_op(OP_WRITE,  8'h55, 16'd0);
        queue_op(OP_REMOVE, 8'h00, 16'd2);
        queue_op(OP_WRITE,  8'h66, 16'd0);
        queue_op(OP_WRITE,  8'h77, 16'd0);
        queue_op(OP_READ,   8'h00, 16'd2);
        queue_op(OP_REMOVE, 8'h00, 16'd3);
        wait_drained();

        // random phases across capacities, out-of-range settings included
        cap_plan[7] = $urandom_range(4, 255);
        foreach (cap_plan[k]) begin
            write_capacity(CFG_W'(cap_plan[k]));
            idling_on = ($urandom_range(0, 3) != 0);
            random_phase(52);
            wait_drained();
        end

        // last part runs without idling on either side
        idling_on = 1'b0;
        write_capacity(9'd5);
        random_phase(40);
        wait_drained();

        repeat (16) @(negedge aclk);
        if (owed_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", owed_results.size()));
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
